/* hdl/sit_pkg.sv */
// Package for the sorted identifier table: sizes, command codes, FSM states
// and the control bundle that the controller drives into every cell.
// No dependencies.
package sit_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SRCH_W = CNT_W + 1;
  localparam int ID_W   = 32;
  localparam int ADDR_W = 32;
  localparam int CAP_W  = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_SRCH,
    S_READ
  } state_t;

  typedef struct packed {
    logic              cmp_en;
    logic              ins_en;
    logic [ID_W-1:0]   key;
    logic [ADDR_W-1:0] addr;
  } cell_ctl_t;

endpackage

/* hdl/sit_cell.sv */
// One table cell: holds an (identifier, address) pair, keeps compare flags
// against the current key and shifts up from its lower neighbour on insert.
// Depends on sit_pkg.
module sit_cell (
  input  logic                      clk,
  input  sit_pkg::cell_ctl_t        ctl,
  input  logic [sit_pkg::IDX_W-1:0] cell_idx,
  input  logic [sit_pkg::CNT_W-1:0] count,
  input  logic [sit_pkg::ID_W-1:0]  prev_id,
  input  logic [sit_pkg::ADDR_W-1:0] prev_addr,
  input  logic                      prev_move,
  output logic [sit_pkg::ID_W-1:0]  id,
  output logic [sit_pkg::ADDR_W-1:0] addr,
  output logic                      gt,
  output logic                      eq,
  output logic                      move
);
  import sit_pkg::*;

  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              gt_r, eq_r;
  logic              used;

  assign used = CNT_W'(cell_idx) < count;
  // this cell is at or above the insertion point
  assign move = (used && gt_r) || (CNT_W'(cell_idx) == count);

  always_comb begin
    id_nxt   = id_r;
    addr_nxt = addr_r;
    if (ctl.ins_en && move) begin
      if (prev_move) begin
        id_nxt   = prev_id;
        addr_nxt = prev_addr;
      end else begin
        id_nxt   = ctl.key;
        addr_nxt = ctl.addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    addr_r <= addr_nxt;
    if (ctl.cmp_en) begin
      gt_r <= id_r > ctl.key;
      eq_r <= id_r == ctl.key;
    end
  end

  assign id   = id_r;
  assign addr = addr_r;
  assign gt   = gt_r;
  assign eq   = eq_r;

endmodule

/* hdl/sit_ctrl.sv */
// Command sequencer: compare pass, insert state, binary search over the
// cells' compare flags, result register and capacity register.
// Depends on sit_pkg.
module sit_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic [sit_pkg::ID_W-1:0]   in_key_id,
  input  logic [sit_pkg::ADDR_W-1:0] in_value_addr,
  input  logic                       cfg_valid,
  input  logic [sit_pkg::CAP_W-1:0]  cfg_capacity,
  output sit_pkg::cell_ctl_t         ctl,
  output logic [sit_pkg::CNT_W-1:0]  count,
  output logic [sit_pkg::IDX_W-1:0]  sel_idx,
  input  logic [sit_pkg::ADDR_W-1:0] sel_addr,
  input  logic [sit_pkg::DEPTH-1:0]  gt_vec,
  input  logic [sit_pkg::DEPTH-1:0]  eq_vec,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [sit_pkg::ADDR_W-1:0] out_found_addr,
  output logic [sit_pkg::CNT_W-1:0]  out_entry_count
);
  import sit_pkg::*;

  state_t                    state_r, state_nxt;
  logic                      cmd_r, cmd_nxt;
  logic [ID_W-1:0]           key_r, key_nxt;
  logic [ADDR_W-1:0]         val_r, val_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CAP_W-1:0]          cap_r;
  logic signed [SRCH_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      ov_r, ov_nxt, ok_r, ok_nxt;
  logic [ADDR_W-1:0]         fa_r, fa_nxt;
  logic [CNT_W-1:0]          ec_r, ec_nxt;
  logic [CAP_W-1:0]          eff_cap;
  logic                      full;

  assign eff_cap = (cap_r > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_r;
  assign full    = count_r >= CNT_W'(eff_cap);
  assign mid     = lo_r + ((hi_r - lo_r) >>> 1);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    ok_nxt    = ok_r;
    fa_nxt    = fa_r;
    ec_nxt    = ec_r;
    ctl.cmp_en = 1'b0;
    ctl.ins_en = 1'b0;
    ctl.key    = key_r;
    ctl.addr   = val_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_key_id;
          val_nxt   = in_value_addr;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmp_en = 1'b1;
        if (cmd_r == CMD_INSERT) begin
          if (full) begin
            ov_nxt    = 1'b1;
            ok_nxt    = 1'b0;
            fa_nxt    = '0;
            ec_nxt    = count_r;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_INS;
          end
        end else begin
          lo_nxt    = '0;
          hi_nxt    = $signed({1'b0, count_r}) - SRCH_W'(1);
          state_nxt = S_SRCH;
        end
      end
      S_INS: begin
        ctl.ins_en = 1'b1;
        count_nxt  = count_r + CNT_W'(1);
        ov_nxt     = 1'b1;
        ok_nxt     = 1'b1;
        fa_nxt     = '0;
        ec_nxt     = count_r + CNT_W'(1);
        state_nxt  = S_IDLE;
      end
      S_SRCH: begin
        if (lo_r > hi_r) begin
          ov_nxt    = 1'b1;
          ok_nxt    = 1'b0;
          fa_nxt    = '0;
          ec_nxt    = count_r;
          state_nxt = S_IDLE;
        end else if (eq_vec[mid[IDX_W-1:0]]) begin
          idx_nxt   = mid[IDX_W-1:0];
          state_nxt = S_READ;
        end else if (gt_vec[mid[IDX_W-1:0]]) begin
          hi_nxt = mid - SRCH_W'(1);
        end else begin
          lo_nxt = mid + SRCH_W'(1);
        end
      end
      S_READ: begin
        ov_nxt    = 1'b1;
        ok_nxt    = 1'b1;
        fa_nxt    = sel_addr;
        ec_nxt    = count_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cap_r   <= CAP_W'(DEPTH);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    idx_r <= idx_nxt;
    ok_r  <= ok_nxt;
    fa_r  <= fa_nxt;
    ec_r  <= ec_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign count           = count_r;
  assign sel_idx         = idx_r;
  assign out_valid       = ov_r;
  assign out_ok          = ok_r;
  assign out_found_addr  = fa_r;
  assign out_entry_count = ec_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not bump entry count");

  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |-> !full)
    else $error("insert into full table");

  a_miss_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ok_r) |-> fa_r == '0)
    else $error("non-zero address on failed command");

endmodule

/* hdl/sorted_id_table_unit.sv */
// Sorted identifier table: a chain of DEPTH cells kept in ascending id order.
// Insert runs a compare pass, then the insert unless the table is full; lookup
// runs a compare pass, then a binary search stepping one probe a cycle over the
// cells' compare flags, then on a hit reads the matching cell's address.
// One command at a time, results never held off; start is taken again in the
// cycle out_valid shows. Sync active-low reset empties table, capacity = DEPTH.
module sorted_id_table_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic [sit_pkg::ID_W-1:0]   in_key_id,
  input  logic [sit_pkg::ADDR_W-1:0] in_value_addr,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sit_pkg::CAP_W-1:0]  cfg_capacity,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [sit_pkg::ADDR_W-1:0] out_found_addr,
  output logic [sit_pkg::CNT_W-1:0]  out_entry_count
);
  import sit_pkg::*;

  cell_ctl_t         ctl;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  sel_idx;
  logic [ADDR_W-1:0] sel_addr;
  logic [DEPTH-1:0]  gt_vec, eq_vec, move_vec;
  logic [ID_W-1:0]   id_w   [DEPTH];
  logic [ADDR_W-1:0] addr_w [DEPTH];

  assign cfg_ready = 1'b1;

  sit_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key_id       (in_key_id),
    .in_value_addr   (in_value_addr),
    .cfg_valid       (cfg_valid),
    .cfg_capacity    (cfg_capacity),
    .ctl             (ctl),
    .count           (count),
    .sel_idx         (sel_idx),
    .sel_addr        (sel_addr),
    .gt_vec          (gt_vec),
    .eq_vec          (eq_vec),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_found_addr  (out_found_addr),
    .out_entry_count (out_entry_count)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_W-1:0]   p_id;
    logic [ADDR_W-1:0] p_addr;
    logic              p_move;
    if (g == 0) begin : g_first
      assign p_id   = '0;
      assign p_addr = '0;
      assign p_move = 1'b0;
    end else begin : g_rest
      assign p_id   = id_w[g-1];
      assign p_addr = addr_w[g-1];
      assign p_move = move_vec[g-1];
    end
    sit_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (IDX_W'(g)),
      .count     (count),
      .prev_id   (p_id),
      .prev_addr (p_addr),
      .prev_move (p_move),
      .id        (id_w[g]),
      .addr      (addr_w[g]),
      .gt        (gt_vec[g]),
      .eq        (eq_vec[g]),
      .move      (move_vec[g])
    );
  end

  // address of the matching cell, AND-OR select
  always_comb begin
    sel_addr = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_idx == IDX_W'(i)) begin
        sel_addr = sel_addr | addr_w[i];
      end
    end
  end

endmodule

/* sim/sorted_id_table_unit_test.sv */
// Testbench for sorted_id_table_unit: insert and lookup commands against a shadow
// copy of the sorted table, with capacity changes between phases.
// Depends on sit_pkg and the sorted_id_table_unit RTL.
module sorted_id_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  // Shadow of the table: works out the reply to each accepted transaction
  class id_table_shadow;
    typedef struct {
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  count;
    } reply_t;

    logic [ID_W-1:0]   ids [DEPTH];
    logic [ADDR_W-1:0] addrs [DEPTH];
    int                used;
    logic [CAP_W-1:0]  cap;
    reply_t            pending [$];
    int                errors;

    function new();
      used   = 0;
      cap    = CAP_W'(DEPTH);
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      cap = value;
    endfunction

    function int limit();
      return (cap > DEPTH) ? DEPTH : int'(cap);
    endfunction

    // new pair goes after every entry with an equal id
    function bit insert_pair(logic [ID_W-1:0] key, logic [ADDR_W-1:0] addr);
      int pos;
      if (used >= limit()) return 1'b0;
      pos = used;
      for (int i = 0; i < used; i++) begin
        if (ids[i] > key) begin
          pos = i;
          break;
        end
      end
      for (int i = used; i > pos; i--) begin
        ids[i]   = ids[i-1];
        addrs[i] = addrs[i-1];
      end
      ids[pos]   = key;
      addrs[pos] = addr;
      used++;
      return 1'b1;
    endfunction

    // binary search; first probed match wins among duplicates
    function bit search_table(logic [ID_W-1:0] key, output logic [ADDR_W-1:0] addr);
      int lo;
      int hi;
      int mid;
      addr = '0;
      lo   = 0;
      hi   = used - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (ids[mid] == key) begin
          addr = addrs[mid];
          return 1'b1;
        end
        if (ids[mid] > key) hi = mid - 1;
        else lo = mid + 1;
      end
      return 1'b0;
    endfunction

    function void note_command(logic cmd, logic [ID_W-1:0] key, logic [ADDR_W-1:0] value);
      reply_t r;
      r.addr = '0;
      if (cmd == CMD_INSERT) r.ok = insert_pair(key, value);
      else r.ok = search_table(key, r.addr);
      r.count = CNT_W'(used);
      pending.push_back(r);
    endfunction

    function void mismatch(string field, longint unsigned exp, longint unsigned act);
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp, act);
      errors++;
    endfunction

    function void check_reply(logic ok, logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] count);
      reply_t r;
      if (pending.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      r = pending.pop_front();
      if (ok !== r.ok) mismatch("ok", r.ok, ok);
      if (addr !== r.addr) mismatch("found_addr", r.addr, addr);
      if (count !== r.count) mismatch("entry_count", r.count, count);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_cmd = CMD_INSERT;
  logic [ID_W-1:0]   in_key_id = '0;
  logic [ADDR_W-1:0] in_value_addr = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_capacity = '0;
  logic              out_valid;
  logic              out_ok;
  logic [ADDR_W-1:0] out_found_addr;
  logic [CNT_W-1:0]  out_entry_count;

  id_table_shadow    shadow = new();
  logic [ID_W-1:0]   known_ids [$];
  bit                steady_flow = 1'b0;

  sorted_id_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key_id       (in_key_id),
    .in_value_addr   (in_value_addr),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_found_addr  (out_found_addr),
    .out_entry_count (out_entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) shadow.check_reply(out_ok, out_found_addr, out_entry_count);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bias towards ids already offered so lookups hit and duplicates appear
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    logic [ID_W-1:0] base;
    r = $urandom_range(0, 99);
    if (known_ids.size() != 0) begin
      base = known_ids[$urandom_range(0, known_ids.size() - 1)];
      if (r < 45) return base;
      if (r < 55) return base + 32'd1;
      if (r < 62) return base - 32'd1;
    end
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    return $urandom;
  endfunction

  task automatic issue_command(logic cmd, logic [ID_W-1:0] key, logic [ADDR_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_key_id     <= key;
    in_value_addr <= value;
    do @(posedge clk); while (busy);
    shadow.note_command(cmd, key, value);
    if (cmd == CMD_INSERT) known_ids.push_back(key);
  endtask

  // capacity only changes with the table idle
  task automatic write_capacity(logic [CAP_W-1:0] value);
    start <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_capacity(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] phase_caps [8];
    logic             cmd;
    bit               want_insert;

    phase_caps = '{7'd24, 7'd10, 7'd0, 7'd48, 7'd127, 7'd64, 7'd0, 7'd64};
    phase_caps[2] = CAP_W'($urandom_range(0, 127));
    phase_caps[6] = CAP_W'($urandom_range(0, 127));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table lookups
    issue_command(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    issue_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

    // zero capacity refuses an insert
    write_capacity(7'd0);
    issue_command(CMD_INSERT, 32'h0000_0005, 32'h0000_1234);

    write_capacity(7'd3);
    issue_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    issue_command(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    issue_command(CMD_INSERT, 32'h0000_0007, 32'h0000_0001);
    issue_command(CMD_LOOKUP, 32'h0000_0000, 32'hDEAD_BEEF);
    issue_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_command(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    issue_command(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);

    // above DEPTH clamps to DEPTH; duplicates stay in arrival order
    write_capacity(7'd127);
    issue_command(CMD_INSERT, 32'h8000_0000, 32'h0000_0001);
    issue_command(CMD_INSERT, 32'h8000_0000, 32'h0000_0002);
    issue_command(CMD_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    issue_command(CMD_INSERT, 32'h0000_0000, 32'h1111_1111);
    issue_command(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    issue_command(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    issue_command(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue_command(CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000);

    // capacity below the count: full, nothing dropped
    write_capacity(7'd2);
    issue_command(CMD_INSERT, 32'h0000_0010, 32'h0000_0010);
    issue_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      steady_flow = (p % 3 == 1);
      repeat (60) begin
        if (shadow.used < shadow.limit()) want_insert = ($urandom_range(0, 99) < 55);
        else want_insert = ($urandom_range(0, 99) < 15);
        cmd = want_insert ? CMD_INSERT : CMD_LOOKUP;
        issue_command(cmd, pick_id(), pick_addr());
      end
    end

    start <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* sorted_id_table_unit.f */
hdl/sit_pkg.sv
hdl/sit_cell.sv
hdl/sit_ctrl.sv
hdl/sorted_id_table_unit.sv
sim/sorted_id_table_unit_test.sv
